// ===== hdl/pmds_pkg.sv =====
package pmds_pkg;

   localparam int REF_W     = 32;
   localparam int BEST_W    = 33;
   localparam int SDIV_W    = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_CEILING     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALLEST_DIVIDER = 2'd2;

   localparam logic [REF_W-1:0]  RESET_REFERENCE_RATE   = 32'd24000000;
   localparam logic [REF_W-1:0]  RESET_RATE_CEILING     = 32'd1000000000;
   localparam logic [SDIV_W-1:0] RESET_SMALLEST_DIVIDER = 8'd1;

   // Program addresses of the sequencer.
   typedef enum logic [2:0] {
      PC_IDLE,
      PC_DTOP,
      PC_DIV,
      PC_MINIT,
      PC_MSTEP,
      PC_EVAL,
      PC_NEXTD,
      PC_FINISH
   } pc_type;

   // Datapath actions.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DSTART,
      OP_MINIT,
      OP_MSTEP,
      OP_EVAL,
      OP_NEXTD,
      OP_EMIT
   } op_type;

   // Branch conditions.
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_SEARCH_DONE,
      COND_DIV_DONE,
      COND_MORE_M,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   on_true;
      pc_type   on_false;
   } ctl_word_type;

   // The control store: one word per program step.
   function automatic ctl_word_type ctl_rom(input pc_type pc);
      ctl_word_type w;
      unique case (pc)
         PC_IDLE:   w = '{OP_LOAD,   COND_ACCEPT,      PC_DTOP,   PC_IDLE};
         PC_DTOP:   w = '{OP_DSTART, COND_SEARCH_DONE, PC_FINISH, PC_DIV};
         PC_DIV:    w = '{OP_NONE,   COND_DIV_DONE,    PC_MINIT,  PC_DIV};
         PC_MINIT:  w = '{OP_MINIT,  COND_ALWAYS,      PC_MSTEP,  PC_MSTEP};
         PC_MSTEP:  w = '{OP_MSTEP,  COND_ALWAYS,      PC_EVAL,   PC_EVAL};
         PC_EVAL:   w = '{OP_EVAL,   COND_MORE_M,      PC_MSTEP,  PC_NEXTD};
         PC_NEXTD:  w = '{OP_NEXTD,  COND_ALWAYS,      PC_DTOP,   PC_DTOP};
         PC_FINISH: w = '{OP_EMIT,   COND_OUT_FREE,    PC_IDLE,   PC_FINISH};
         default:   w = '{OP_NONE,   COND_ALWAYS,      PC_IDLE,   PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/pmds_divider.sv =====
module pmds_divider #(
   parameter int DIVIDEND_W = 32,
   parameter int DIVISOR_W  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;
   logic                  fits;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      trial     = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits      = trial >= {1'b0, divisor};
      trial_sub = trial - {1'b0, divisor};
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/pll_mult_div_search_core.sv =====
// Finds the PLL multiplier and divider whose output floor(ref * m / d) comes closest to the
// requested rate, after lowering the request to the ceiling register when one is set. The
// search is run by a small microprogram: for each divider a serial division gives ref / d,
// then each multiplier takes an accumulate step and a compare step; an exact hit ends the
// search early. One request is in the search at a time; a finished result waits in the
// output register while the next request is taken. Configuration writes are always taken
// and must only be made while idle.
module pll_mult_div_search_core #(
   parameter int MAX_DIVIDER    = 128,
   parameter int MAX_MULTIPLIER = 2047
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pmds_pkg::REF_W-1:0]          req_requested_rate,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [pmds_pkg::BEST_W-1:0]         rsp_achieved_rate,
   output logic [$clog2(MAX_MULTIPLIER+1)-1:0] rsp_chosen_mult,
   output logic [$clog2(MAX_DIVIDER+1)-1:0]    rsp_chosen_div,
   output logic                                rsp_rate_clamped,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pmds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pmds_pkg::REF_W-1:0]          csr_data
);

   import pmds_pkg::*;

   localparam int DIV_W  = $clog2(MAX_DIVIDER + 1);
   localparam int MULT_W = $clog2(MAX_MULTIPLIER + 1);
   localparam int RATE_W = REF_W + MULT_W;

   // Configuration registers.
   logic [REF_W-1:0]  reference_rate_ff;
   logic [REF_W-1:0]  rate_ceiling_ff;
   logic [SDIV_W-1:0] smallest_div_ff;

   // Sequencer.
   pc_type       pc_ff, pc_in;
   ctl_word_type word;
   logic         cond_true;

   // Datapath.
   logic [REF_W-1:0]  req_ff, req_in;
   logic              clamped_ff, clamped_in;
   logic [REF_W-1:0]  err_ff, err_in;
   logic              hit_ff, hit_in;
   logic [BEST_W-1:0] kept_rate_ff, kept_rate_in;
   logic [MULT_W-1:0] best_mult_ff, best_mult_in;
   logic [DIV_W-1:0]  best_div_ff, best_div_in;
   logic [DIV_W:0]    d_ff, d_in;
   logic [MULT_W-1:0] m_ff, m_in;
   logic [RATE_W-1:0] q_ff, q_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic              more_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [BEST_W-1:0] rsp_rate_ff;
   logic [MULT_W-1:0] rsp_mult_ff;
   logic [DIV_W-1:0]  rsp_div_ff;
   logic              rsp_clamped_ff;

   logic               req_beat;
   logic               out_free;
   logic               div_start;
   logic               div_busy;
   logic [REF_W-1:0]   step_quo;
   logic [DIV_W-1:0]   step_rem;
   logic [DIV_W:0]     rem_sum;
   logic [DIV_W:0]     rem_wrap;
   logic [RATE_W-1:0]  req_ext;
   logic [RATE_W-1:0]  err_now;
   logic               better;
   logic               sdiv_ok;

   assign csr_ready = 1'b1;
   assign req_stall = (pc_ff != PC_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign word      = ctl_rom(pc_ff);
   assign div_start = (word.op == OP_DSTART);

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_rate_ff <= RESET_REFERENCE_RATE;
         rate_ceiling_ff   <= RESET_RATE_CEILING;
         smallest_div_ff   <= RESET_SMALLEST_DIVIDER;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REFERENCE_RATE:   reference_rate_ff <= csr_data;
            CSR_RATE_CEILING:     rate_ceiling_ff   <= csr_data;
            CSR_SMALLEST_DIVIDER: smallest_div_ff   <= csr_data[SDIV_W-1:0];
            default: ;
         endcase
      end
   end

   // ref / d for the divider under test; stepping m then adds this quotient and remainder.
   pmds_divider #(
      .DIVIDEND_W (REF_W),
      .DIVISOR_W  (DIV_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (reference_rate_ff),
      .divisor   (d_ff[DIV_W-1:0]),
      .busy      (div_busy),
      .quotient  (step_quo),
      .remainder (step_rem)
   );

   // Branch condition of the current control word.
   always_comb begin
      case (word.cond)
         COND_ALWAYS:      cond_true = 1'b1;
         COND_ACCEPT:      cond_true = req_beat;
         COND_SEARCH_DONE: cond_true = (err_ff == '0) ||
                                       (d_ff > (DIV_W+1)'(MAX_DIVIDER));
         COND_DIV_DONE:    cond_true = !div_busy;
         COND_MORE_M:      cond_true = more_in;
         COND_OUT_FREE:    cond_true = out_free;
         default:          cond_true = 1'b1;
      endcase
   end

   // Next program step.
   always_comb begin
      pc_in = cond_true ? word.on_true : word.on_false;
   end

   always_comb begin
      sdiv_ok  = (smallest_div_ff != '0) &&
                 (32'(smallest_div_ff) <= 32'(MAX_DIVIDER));
      rem_sum  = {1'b0, rem_ff} + {1'b0, step_rem};
      rem_wrap = rem_sum - d_ff;
      req_ext  = RATE_W'(req_ff);
      err_now  = (q_ff >= req_ext) ? (q_ff - req_ext) : (req_ext - q_ff);
      better   = err_now < RATE_W'(err_ff);

      req_in       = req_ff;
      clamped_in   = clamped_ff;
      err_in       = err_ff;
      hit_in       = hit_ff;
      kept_rate_in = kept_rate_ff;
      best_mult_in = best_mult_ff;
      best_div_in  = best_div_ff;
      d_in         = d_ff;
      m_in         = m_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      more_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (word.op)
         OP_LOAD: begin
            if (req_beat) begin
               if ((rate_ceiling_ff != '0) && (req_requested_rate > rate_ceiling_ff)) begin
                  req_in     = rate_ceiling_ff;
                  err_in     = rate_ceiling_ff;
                  clamped_in = 1'b1;
               end else begin
                  req_in     = req_requested_rate;
                  err_in     = req_requested_rate;
                  clamped_in = 1'b0;
               end
               hit_in       = 1'b0;
               kept_rate_in = '0;
               best_mult_in = '0;
               best_div_in  = '0;
               d_in         = sdiv_ok ? (DIV_W+1)'(smallest_div_ff) : (DIV_W+1)'(1);
            end
         end
         OP_MINIT: begin
            m_in   = MULT_W'(1);
            q_in   = RATE_W'(step_quo);
            rem_in = step_rem;
         end
         OP_MSTEP: begin
            m_in = m_ff + MULT_W'(1);
            // The remainder sum stays below twice the divider, so one wrap is enough.
            if (rem_sum >= d_ff) begin
               rem_in = rem_wrap[DIV_W-1:0];
               q_in   = q_ff + RATE_W'(step_quo) + RATE_W'(1);
            end else begin
               rem_in = rem_sum[DIV_W-1:0];
               q_in   = q_ff + RATE_W'(step_quo);
            end
         end
         OP_EVAL: begin
            if (better) begin
               err_in       = err_now[REF_W-1:0];
               hit_in       = 1'b1;
               kept_rate_in = q_ff[BEST_W-1:0];
               best_mult_in = m_ff;
               best_div_in  = d_ff[DIV_W-1:0];
            end
            more_in = (m_ff != MULT_W'(MAX_MULTIPLIER)) &&
                      !(better && (err_now == '0)) &&
                      !(!better && (q_ff > req_ext));
         end
         OP_NEXTD: begin
            d_in = d_ff + (DIV_W+1)'(1);
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      clamped_ff   <= clamped_in;
      err_ff       <= err_in;
      hit_ff       <= hit_in;
      kept_rate_ff <= kept_rate_in;
      best_mult_ff <= best_mult_in;
      best_div_ff  <= best_div_in;
      d_ff         <= d_in;
      m_ff         <= m_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      if ((word.op == OP_EMIT) && out_free) begin
         rsp_found_ff   <= hit_ff;
         rsp_rate_ff    <= kept_rate_ff;
         rsp_mult_ff    <= best_mult_ff;
         rsp_div_ff     <= best_div_ff;
         rsp_clamped_ff <= clamped_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_achieved_rate = rsp_rate_ff;
   assign rsp_chosen_mult   = rsp_mult_ff;
   assign rsp_chosen_div    = rsp_div_ff;
   assign rsp_rate_clamped  = rsp_clamped_ff;

endmodule

// ===== hdl/pmds_checker.sv =====
module pmds_checker #(
   parameter int MULT_W = 11,
   parameter int DIV_W  = 8
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_found,
   input logic [pmds_pkg::BEST_W-1:0]   rsp_achieved_rate,
   input logic [MULT_W-1:0]             rsp_chosen_mult,
   input logic [DIV_W-1:0]              rsp_chosen_div,
   input logic                          rsp_rate_clamped
);

   import pmds_pkg::*;

   // A result beat that is held back keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_achieved_rate) && $stable(rsp_chosen_mult) &&
      $stable(rsp_chosen_div) && $stable(rsp_rate_clamped))
      else $error("result beat changed while stalled");

   // A not-found result carries no rate, multiplier or divider.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
      (rsp_achieved_rate == '0) && (rsp_chosen_mult == '0) && (rsp_chosen_div == '0))
      else $error("not-found result with nonzero fields");

   // A chosen pair always lies inside the search range.
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
      (rsp_chosen_mult >= MULT_W'(2)) && (rsp_chosen_div != '0))
      else $error("chosen pair outside the search range");

   // A search follows every accepted request, so the block holds off the next request at once.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a search was starting");

endmodule

bind pll_mult_div_search_core pmds_checker #(
   .MULT_W ($clog2(MAX_MULTIPLIER + 1)),
   .DIV_W  ($clog2(MAX_DIVIDER + 1))
) u_pmds_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_found         (rsp_found),
   .rsp_achieved_rate (rsp_achieved_rate),
   .rsp_chosen_mult   (rsp_chosen_mult),
   .rsp_chosen_div    (rsp_chosen_div),
   .rsp_rate_clamped  (rsp_rate_clamped)
);

// ===== verif/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pmds_pkg::*;

   localparam int MAX_DIV       = 128;
   localparam int MAX_MUL       = 2047;
   localparam int MUL_W         = $clog2(MAX_MUL + 1);
   localparam int DIV_W         = $clog2(MAX_DIV + 1);
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2_000_000;
   localparam int HOLD_OFF_LEN  = 3000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [REF_W-1:0]     RATE_MAX   = '1;

   typedef struct packed {
      logic              found;
      logic [BEST_W-1:0] rate;
      logic [MUL_W-1:0]  mult;
      logic [DIV_W-1:0]  div;
      logic              clamped;
   } pll_choice_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [REF_W-1:0]     req_requested_rate = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_found;
   logic [BEST_W-1:0]    rsp_achieved_rate;
   logic [MUL_W-1:0]     rsp_chosen_mult;
   logic [DIV_W-1:0]     rsp_chosen_div;
   logic                 rsp_rate_clamped;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REF_W-1:0]     csr_data = '0;

   // Register shadow used by the predictor.
   logic [REF_W-1:0]     cfg_reference = RESET_REFERENCE_RATE;
   logic [REF_W-1:0]     cfg_ceiling   = RESET_RATE_CEILING;
   logic [SDIV_W-1:0]    cfg_min_div   = RESET_SMALLEST_DIVIDER;

   pll_choice_type       pending_choices[$];
   pll_choice_type       want;
   int                   n_errors     = 0;
   int                   quiet_cycles = 0;
   int                   hold_off_len = 0;
   int                   hold_left    = 0;
   int                   stall_left   = 0;
   bit                   idle_enable  = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pll_mult_div_search_core #(
      .MAX_DIVIDER    (MAX_DIV),
      .MAX_MULTIPLIER (MAX_MUL)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_requested_rate (req_requested_rate),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_achieved_rate  (rsp_achieved_rate),
      .rsp_chosen_mult    (rsp_chosen_mult),
      .rsp_chosen_div     (rsp_chosen_div),
      .rsp_rate_clamped   (rsp_rate_clamped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // An out-of-range divider register falls back to one.
   function automatic int first_divider();
      return (cfg_min_div == 0 || cfg_min_div > MAX_DIV) ? 1 : int'(cfg_min_div);
   endfunction

   function automatic pll_choice_type search_pll_choice(input logic [REF_W-1:0] request);
      pll_choice_type res;
      logic [63:0] target;
      logic [63:0] best_err;
      logic [63:0] rate;
      logic [63:0] err;
      res = '0;
      target = 64'(request);
      if (cfg_ceiling != 0 && request > cfg_ceiling) begin
         target = 64'(cfg_ceiling);
         res.clamped = 1'b1;
      end
      // The kept error starts at the target rate, so only a strictly closer pair counts.
      best_err = target;
      for (int d = first_divider(); best_err != 0 && d <= MAX_DIV; d++) begin
         for (int m = 2; m <= MAX_MUL; m++) begin
            rate = (64'(cfg_reference) * 64'(m)) / 64'(d);
            err  = (rate >= target) ? rate - target : target - rate;
            if (err < best_err) begin
               best_err    = err;
               res.found   = 1'b1;
               res.rate    = rate[BEST_W-1:0];
               res.mult    = m[MUL_W-1:0];
               res.div     = d[DIV_W-1:0];
               if (err == 0) break;
            end else if (rate > target) begin
               break;
            end
         end
      end
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_enable || roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   // A rate the PLL can produce exactly with one of the first few dividers, so the
   // search ends early on an exact hit.
   function automatic logic [REF_W-1:0] reachable_rate();
      logic [63:0] rate;
      int d;
      int m;
      int roll;
      d = first_divider() + $urandom_range(0, 3);
      if (d > MAX_DIV) d = MAX_DIV;
      roll = $urandom_range(0, 9);
      if (roll < 7)      m = $urandom_range(2, 64);
      else if (roll < 9) m = $urandom_range(65, 512);
      else               m = $urandom_range(513, MAX_MUL);
      rate = (64'(cfg_reference) * 64'(m)) / 64'(d);
      while (m > 2 && (rate > 64'(RATE_MAX) || (cfg_ceiling != 0 && rate > cfg_ceiling))) begin
         m = (m / 2 < 2) ? 2 : m / 2;
         rate = (64'(cfg_reference) * 64'(m)) / 64'(d);
      end
      return rate[REF_W-1:0];
   endfunction

   task automatic send_rate(input logic [REF_W-1:0] rate);
      int gap;
      req_valid          <= 1'b1;
      req_requested_rate <= rate;
      do @(posedge clock); while (req_stall);
      pending_choices.push_back(search_pll_choice(rate));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [REF_W-1:0] value,
                            input bit last_write);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_REFERENCE_RATE:   cfg_reference = value;
         CSR_RATE_CEILING:     cfg_ceiling   = value;
         CSR_SMALLEST_DIVIDER: cfg_min_div   = value[SDIV_W-1:0];
         default: ;
      endcase
      if (last_write) csr_valid <= 1'b0;
   endtask

   task automatic program_pll(input logic [REF_W-1:0] reference, input logic [REF_W-1:0] ceiling,
                              input logic [REF_W-1:0] min_div);
      write_csr(CSR_REFERENCE_RATE, reference, 1'b0);
      write_csr(CSR_RATE_CEILING, ceiling, 1'b0);
      write_csr(CSR_SMALLEST_DIVIDER, min_div, 1'b1);
   endtask

   // Registers may only change once the block has gone quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_default_settings();
      send_rate('0);
      send_rate(32'd120000000);
      send_rate(RATE_MAX);
      send_rate(32'd1);
      send_rate(RESET_RATE_CEILING);
      send_rate(RESET_RATE_CEILING + 32'd1);
      drain_results();
   endtask

   task automatic test_divider_register();
      program_pll(RESET_REFERENCE_RATE, '0, 32'd128);
      send_rate(RATE_MAX);
      send_rate(32'd383812500);
      drain_results();
      write_csr(CSR_SMALLEST_DIVIDER, 32'd0, 1'b1);
      send_rate(32'd72000000);
      drain_results();
      write_csr(CSR_SMALLEST_DIVIDER, 32'd200, 1'b1);
      send_rate(32'd48000000);
      drain_results();
      write_csr(CSR_SMALLEST_DIVIDER, 32'd255, 1'b1);
      send_rate(32'd96000000);
      drain_results();
      // A write to an unused index must leave every register alone.
      write_csr(CSR_UNUSED, RATE_MAX, 1'b1);
      send_rate(32'd96000000);
      drain_results();
   endtask

   task automatic test_reference_extremes();
      // With no reference clock nothing is reachable; a single divider keeps the scan short.
      program_pll('0, RESET_RATE_CEILING, 32'd128);
      send_rate(32'd12345);
      send_rate(RATE_MAX);
      drain_results();
      program_pll(RATE_MAX, '0, 32'd1);
      send_rate(RATE_MAX);
      send_rate(32'h8000_0000);
      drain_results();
      write_csr(CSR_RATE_CEILING, RATE_MAX, 1'b1);
      send_rate(RATE_MAX);
      drain_results();
   endtask

   task automatic test_backpressure();
      program_pll(RESET_REFERENCE_RATE, RESET_RATE_CEILING, 32'(RESET_SMALLEST_DIVIDER));
      idle_enable  = 1'b0;
      hold_off_len = HOLD_OFF_LEN;
      for (int k = 2; k <= 7; k++) send_rate(RESET_REFERENCE_RATE * k);
      drain_results();
      idle_enable = 1'b1;
   endtask

   task automatic test_reachable_rates();
      idle_enable = 1'b0;
      for (int i = 0; i < 12; i++) send_rate(reachable_rate());
      idle_enable = 1'b1;
      for (int i = 0; i < 16; i++) send_rate(reachable_rate());
      drain_results();
      program_pll($urandom_range(1000000, 100000000),
                  ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom,
                  $urandom_range(1, MAX_DIV));
      for (int i = 0; i < 16; i++) send_rate(reachable_rate());
      drain_results();
   endtask

   task automatic test_random_requests();
      // Only the last few dividers are tried, which bounds the cost of a miss.
      for (int round = 0; round < 2; round++) begin
         program_pll($urandom, (round == 0) ? $urandom : 32'd0, $urandom_range(124, MAX_DIV));
         for (int i = 0; i < 10; i++) send_rate($urandom);
         drain_results();
      end
   endtask

   task automatic test_large_reference();
      program_pll($urandom_range(32'h8000_0000, RATE_MAX), '0, 32'd1);
      for (int i = 0; i < 12; i++) begin
         if (i % 2 == 0) send_rate(reachable_rate());
         else            send_rate($urandom);
      end
      drain_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_settings();
      test_divider_register();
      test_reference_extremes();
      test_backpressure();
      test_reachable_rates();
      test_random_requests();
      test_large_reference();
      if (n_errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // Result side: check each accepted beat, then decide the stall for the next cycle.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (pending_choices.size() == 0) begin
            $error("result beat with no request outstanding");
            n_errors++;
         end else begin
            want = pending_choices.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               n_errors++;
            end
            if (rsp_achieved_rate !== want.rate) begin
               $error("achieved_rate: expected %0d, got %0d", want.rate, rsp_achieved_rate);
               n_errors++;
            end
            if (rsp_chosen_mult !== want.mult) begin
               $error("chosen_mult: expected %0d, got %0d", want.mult, rsp_chosen_mult);
               n_errors++;
            end
            if (rsp_chosen_div !== want.div) begin
               $error("chosen_div: expected %0d, got %0d", want.div, rsp_chosen_div);
               n_errors++;
            end
            if (rsp_rate_clamped !== want.clamped) begin
               $error("rate_clamped: expected %0d, got %0d", want.clamped, rsp_rate_clamped);
               n_errors++;
            end
         end
      end
      if (hold_off_len > 0) begin
         hold_left    = hold_off_len;
         hold_off_len = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== sim.f =====
hdl/pmds_pkg.sv
hdl/pmds_divider.sv
hdl/pll_mult_div_search_core.sv
hdl/pmds_checker.sv
verif/tb_top.sv
